### rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// shared types and constants of the ray/triangle intersection pipeline
// ----------------------------------------------------------------------------
package rti_pkg;

   // fraction bits of the barycentric outputs (Q1.30)
   localparam int BARY_BITS = 30;
   localparam int BARY_W    = 31;
   localparam logic [BARY_W-1:0] BARY_ONE = BARY_W'(1) << BARY_BITS;

   // reciprocal of the parallel-ray epsilon (1e-8)
   localparam int unsigned EPS_RECIP = 100000000;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DIST = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DIST = 3'd7;

   // per-stage control: beat present, and no miss found so far
   typedef struct packed {
      logic valid;
      logic pass;
   } ctl_type;

endpackage

### rtl/core/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// moller-trumbore ray/triangle test, one triangle per clock
// ----------------------------------------------------------------------------
// Takes one triangle beat per clock and returns one result beat per triangle,
// in order. The pipe has four stages of edges and cross products, four of
// dot products and sign fixup, three of range tests, one divider stage per
// quotient bit, and the output register. The divider chain produces one
// quotient bit per stage and sets the latency. A stall on the result side
// freezes the whole pipe; nothing is dropped. The ray (origin, direction,
// distance interval) sits in csr registers that must only be written while
// no triangle is in flight. On a miss bary_u, bary_v and hit_distance read
// zero.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16,
   parameter int TAG_BITS   = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // triangle_tag, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [((TAG_BITS + 9*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_tag, bary_u, bary_v, hit_distance
   output logic [((TAG_BITS + 2*rti_pkg::BARY_W + COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // hit
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [rti_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);

   localparam int CW    = COORD_BITS;
   localparam int TW    = TAG_BITS;
   localparam int BW    = rti_pkg::BARY_W;
   localparam int QB    = (CW > BW) ? CW : BW;
   localparam int EW    = CW + 1;
   localparam int XW    = 2 * CW + 3;
   localparam int DW    = 3 * CW + 6;
   localparam int DVW   = DW + QB;
   localparam int RSP_W = ((TW + 2*BW + CW + 7) / 8) * 8;

   logic signed [CW-1:0] cfg_ff [8];
   logic                 pipe_en;
   rti_pkg::ctl_type     in_ctl;
   logic signed [CW-1:0] vert_a [3], vert_b [3], vert_c [3], org [3], dir [3];

   rti_pkg::ctl_type     fr_ctl;
   logic [TW-1:0]        fr_tag;
   logic signed [EW-1:0] fr_e1 [3], fr_e2 [3], fr_s [3];
   logic signed [XW-1:0] fr_p [3], fr_q [3];
   rti_pkg::ctl_type     dt_ctl;
   logic [TW-1:0]        dt_tag;
   logic signed [DW-1:0] dt_val [4];
   rti_pkg::ctl_type     ck_ctl;
   logic [TW-1:0]        ck_tag;
   logic [DW-1:0]        ck_dsr;
   logic [DVW-1:0]       ck_dvd [3];
   rti_pkg::ctl_type     dv_ctl;
   logic [TW-1:0]        dv_tag;
   logic [QB-1:0]        dv_quo [3];

   logic signed [CW:0]   span;
   logic                 hit_in;
   logic                 rsp_valid_ff;
   logic [TW-1:0]        rsp_tag_ff;
   logic                 rsp_hit_ff;
   logic [BW-1:0]        rsp_u_ff, rsp_v_ff;
   logic signed [CW-1:0] rsp_t_ff;
   logic signed [CW-1:0] min_dist, max_dist;

   // csr registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            if (i == int'(rti_pkg::REG_MAX_DIST)) begin
               cfg_ff[i] <= signed'({1'b0, {(CW-1){1'b1}}});
            end else begin
               cfg_ff[i] <= '0;
            end
         end
      end else if (csr_valid) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   assign org[0]   = cfg_ff[rti_pkg::REG_ORIGIN_X];
   assign org[1]   = cfg_ff[rti_pkg::REG_ORIGIN_Y];
   assign org[2]   = cfg_ff[rti_pkg::REG_ORIGIN_Z];
   assign dir[0]   = cfg_ff[rti_pkg::REG_DIR_X];
   assign dir[1]   = cfg_ff[rti_pkg::REG_DIR_Y];
   assign dir[2]   = cfg_ff[rti_pkg::REG_DIR_Z];
   assign min_dist = cfg_ff[rti_pkg::REG_MIN_DIST];
   assign max_dist = cfg_ff[rti_pkg::REG_MAX_DIST];

   // one enable for the whole pipe, released when the output slot frees up
   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign in_ctl.valid = req_tvalid;
   assign in_ctl.pass  = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vert_a[i] = req_tdata[TW + i*CW +: CW];
         vert_b[i] = req_tdata[TW + (3 + i)*CW +: CW];
         vert_c[i] = req_tdata[TW + (6 + i)*CW +: CW];
      end
   end

   rti_front #(.CW(CW), .TW(TW)) u_front (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_ctl(in_ctl), .in_tag(req_tdata[TW-1:0]),
      .vert_a(vert_a), .vert_b(vert_b), .vert_c(vert_c), .org(org), .dir(dir),
      .out_ctl(fr_ctl), .out_tag(fr_tag),
      .out_e1(fr_e1), .out_e2(fr_e2), .out_s(fr_s), .out_p(fr_p), .out_q(fr_q));

   rti_dot #(.CW(CW), .TW(TW)) u_dot (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_ctl(fr_ctl), .in_tag(fr_tag),
      .in_e1(fr_e1), .in_e2(fr_e2), .in_s(fr_s), .in_p(fr_p), .in_q(fr_q), .dir(dir),
      .out_ctl(dt_ctl), .out_tag(dt_tag), .out_val(dt_val));

   rti_check #(.CW(CW), .TW(TW), .FB(FRAC_BITS), .QB(QB)) u_check (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_ctl(dt_ctl), .in_tag(dt_tag), .in_val(dt_val), .min_dist(min_dist),
      .out_ctl(ck_ctl), .out_tag(ck_tag), .out_dsr(ck_dsr), .out_dvd(ck_dvd));

   rti_div #(.TW(TW), .DW(DW), .QB(QB)) u_div (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_ctl(ck_ctl), .in_tag(ck_tag), .in_dsr(ck_dsr), .in_dvd(ck_dvd),
      .out_ctl(dv_ctl), .out_tag(dv_tag), .out_quo(dv_quo));

   // upper distance bound: t - min must not exceed max - min
   always_comb begin
      span   = (CW+1)'(max_dist) - (CW+1)'(min_dist);
      hit_in = dv_ctl.pass && !span[CW] && ((QB+1)'(dv_quo[2]) <= (QB+1)'(span));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= dv_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_tag_ff <= dv_tag;
         rsp_hit_ff <= hit_in;
         rsp_u_ff   <= hit_in ? dv_quo[0][BW-1:0] : '0;
         rsp_v_ff   <= hit_in ? dv_quo[1][BW-1:0] : '0;
         rsp_t_ff   <= hit_in ? min_dist + CW'(dv_quo[2]) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = RSP_W'({rsp_t_ff, rsp_v_ff, rsp_u_ff, rsp_tag_ff});

   // a miss carries no coordinates
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_u_ff == '0 && rsp_v_ff == '0 && rsp_t_ff == '0)
      else $error("miss with nonzero payload");

   // barycentrics of a hit stay within one
   a_bary_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_u_ff <= rti_pkg::BARY_ONE &&
                                     rsp_v_ff <= rti_pkg::BARY_ONE)
      else $error("barycentric out of range");

   // a hit lies inside the distance interval
   a_dist_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_t_ff >= min_dist && rsp_t_ff <= max_dist)
      else $error("hit distance outside interval");

   // a stall freezes the divider output
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(dv_ctl) && $stable(dv_tag))
      else $error("pipe moved during stall");

endmodule

### rtl/core/rti_mul.sv
// ----------------------------------------------------------------------------
// rti_mul
// two-stage signed multiplier, b operand cut into chunks of partial products
// ----------------------------------------------------------------------------
module rti_mul #(
   parameter int WA  = 33,
   parameter int WB  = 33,
   parameter int NCH = 1
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [WA-1:0]   a,
   input  logic signed [WB-1:0]   b,
   output logic signed [WA+WB-1:0] p
);

   localparam int CH   = (WB + NCH - 1) / NCH;
   localparam int TOPW = WB - CH * (NCH - 1);
   localparam int PPW  = WA + CH + 1;
   localparam int PW   = WA + WB;

   logic signed [PPW-1:0] pp_in [NCH];
   logic signed [PPW-1:0] pp_ff [NCH];
   logic signed [PW-1:0]  p_in;
   logic signed [PW-1:0]  p_ff;

   genvar k;
   generate
      for (k = 0; k < NCH; k++) begin : g_pp
         logic signed [CH:0] bc;
         if (k == NCH - 1) begin : g_top
            // top chunk keeps the sign
            assign bc = signed'({{(CH + 1 - TOPW){b[WB-1]}}, b[WB-1 -: TOPW]});
         end else begin : g_low
            assign bc = signed'({1'b0, b[k*CH +: CH]});
         end
         assign pp_in[k] = PPW'(a) * PPW'(bc);
      end
   endgenerate

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NCH; i++) begin
         p_in = p_in + (PW'(pp_ff[i]) <<< (i * CH));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

### rtl/core/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// edge vectors and the two cross products p = d x e2, q = s x e1
// ----------------------------------------------------------------------------
module rti_front #(
   parameter int CW = 32,
   parameter int TW = 24,
   localparam int EW = CW + 1,
   localparam int XW = 2 * CW + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rti_pkg::ctl_type      in_ctl,
   input  logic [TW-1:0]         in_tag,
   input  logic signed [CW-1:0]  vert_a [3],
   input  logic signed [CW-1:0]  vert_b [3],
   input  logic signed [CW-1:0]  vert_c [3],
   input  logic signed [CW-1:0]  org    [3],
   input  logic signed [CW-1:0]  dir    [3],
   output rti_pkg::ctl_type      out_ctl,
   output logic [TW-1:0]         out_tag,
   output logic signed [EW-1:0]  out_e1 [3],
   output logic signed [EW-1:0]  out_e2 [3],
   output logic signed [EW-1:0]  out_s  [3],
   output logic signed [XW-1:0]  out_p  [3],
   output logic signed [XW-1:0]  out_q  [3]
);

   localparam int MW = 2 * EW;

   rti_pkg::ctl_type      ctl_ff [4];
   logic [TW-1:0]         tag_ff [4];
   logic signed [EW-1:0]  e1_in [3], e2_in [3], s_in [3];
   logic signed [EW-1:0]  e1_ff [4][3];
   logic signed [EW-1:0]  e2_ff [4][3];
   logic signed [EW-1:0]  s_ff  [4][3];
   logic signed [MW-1:0]  pa [3], pb [3], qa [3], qb [3];
   logic signed [XW-1:0]  p_in [3], q_in [3];
   logic signed [XW-1:0]  p_ff [3], q_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EW'(vert_b[i]) - EW'(vert_a[i]);
         e2_in[i] = EW'(vert_c[i]) - EW'(vert_a[i]);
         s_in[i]  = EW'(org[i]) - EW'(vert_a[i]);
      end
   end

   genvar j;
   generate
      for (j = 0; j < 3; j++) begin : g_cross
         localparam int J1 = (j + 1) % 3;
         localparam int J2 = (j + 2) % 3;
         rti_mul #(.WA(EW), .WB(EW), .NCH(1)) u_pa (
            .clock(clock), .en(en), .a(EW'(dir[J1])), .b(e2_ff[0][J2]), .p(pa[j]));
         rti_mul #(.WA(EW), .WB(EW), .NCH(1)) u_pb (
            .clock(clock), .en(en), .a(EW'(dir[J2])), .b(e2_ff[0][J1]), .p(pb[j]));
         rti_mul #(.WA(EW), .WB(EW), .NCH(1)) u_qa (
            .clock(clock), .en(en), .a(s_ff[0][J1]), .b(e1_ff[0][J2]), .p(qa[j]));
         rti_mul #(.WA(EW), .WB(EW), .NCH(1)) u_qb (
            .clock(clock), .en(en), .a(s_ff[0][J2]), .b(e1_ff[0][J1]), .p(qb[j]));
         assign p_in[j] = XW'(pa[j]) - XW'(pb[j]);
         assign q_in[j] = XW'(qa[j]) - XW'(qb[j]);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) ctl_ff[i] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i < 4; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         e1_ff[0]  <= e1_in;
         e2_ff[0]  <= e2_in;
         s_ff[0]   <= s_in;
         for (int i = 1; i < 4; i++) begin
            tag_ff[i] <= tag_ff[i-1];
            e1_ff[i]  <= e1_ff[i-1];
            e2_ff[i]  <= e2_ff[i-1];
            s_ff[i]   <= s_ff[i-1];
         end
         p_ff <= p_in;
         q_ff <= q_in;
      end
   end

   assign out_ctl = ctl_ff[3];
   assign out_tag = tag_ff[3];
   assign out_e1  = e1_ff[3];
   assign out_e2  = e2_ff[3];
   assign out_s   = s_ff[3];
   assign out_p   = p_ff;
   assign out_q   = q_ff;

endmodule

### rtl/core/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot
// det and the three numerators as dot products, then sign normalization
// ----------------------------------------------------------------------------
module rti_dot #(
   parameter int CW = 32,
   parameter int TW = 24,
   localparam int EW = CW + 1,
   localparam int XW = 2 * CW + 3,
   localparam int DW = 3 * CW + 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rti_pkg::ctl_type      in_ctl,
   input  logic [TW-1:0]         in_tag,
   input  logic signed [EW-1:0]  in_e1 [3],
   input  logic signed [EW-1:0]  in_e2 [3],
   input  logic signed [EW-1:0]  in_s  [3],
   input  logic signed [XW-1:0]  in_p  [3],
   input  logic signed [XW-1:0]  in_q  [3],
   input  logic signed [CW-1:0]  dir   [3],
   output rti_pkg::ctl_type      out_ctl,
   output logic [TW-1:0]         out_tag,
   // lanes: det, nu, nv, nt
   output logic signed [DW-1:0]  out_val [4]
);

   localparam int MW = EW + XW;

   rti_pkg::ctl_type      ctl_ff [4];
   logic [TW-1:0]         tag_ff [4];
   logic signed [EW-1:0]  opa  [4][3];
   logic signed [XW-1:0]  opb  [4][3];
   logic signed [MW-1:0]  prod [4][3];
   logic signed [DW-1:0]  sum_in [4];
   logic signed [DW-1:0]  sum_ff [4];
   logic signed [DW-1:0]  norm_in [4];
   logic signed [DW-1:0]  norm_ff [4];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         opa[0][j] = in_e1[j];     opb[0][j] = in_p[j];
         opa[1][j] = in_s[j];      opb[1][j] = in_p[j];
         opa[2][j] = EW'(dir[j]);  opb[2][j] = in_q[j];
         opa[3][j] = in_e2[j];     opb[3][j] = in_q[j];
      end
   end

   genvar l, j;
   generate
      for (l = 0; l < 4; l++) begin : g_lane
         for (j = 0; j < 3; j++) begin : g_term
            rti_mul #(.WA(EW), .WB(XW), .NCH(2)) u_mul (
               .clock(clock), .en(en), .a(opa[l][j]), .b(opb[l][j]), .p(prod[l][j]));
         end
         assign sum_in[l] = DW'(prod[l][0]) + DW'(prod[l][1]) + DW'(prod[l][2]);
         // flip everything so that det ends up non-negative
         assign norm_in[l] = sum_ff[0][DW-1] ? -sum_ff[l] : sum_ff[l];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) ctl_ff[i] <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i < 4; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i < 4; i++) tag_ff[i] <= tag_ff[i-1];
         sum_ff  <= sum_in;
         norm_ff <= norm_in;
      end
   end

   assign out_ctl = ctl_ff[3];
   assign out_tag = tag_ff[3];
   assign out_val = norm_ff;

endmodule

### rtl/core/rti_check.sv
// ----------------------------------------------------------------------------
// rti_check
// parallel and barycentric tests, lower distance bound, divider operands
// ----------------------------------------------------------------------------
module rti_check #(
   parameter int CW = 32,
   parameter int TW = 24,
   parameter int FB = 16,
   parameter int QB = 32,
   localparam int DW  = 3 * CW + 6,
   localparam int DVW = DW + QB
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rti_pkg::ctl_type      in_ctl,
   input  logic [TW-1:0]         in_tag,
   // lanes: det, nu, nv, nt
   input  logic signed [DW-1:0]  in_val [4],
   input  logic signed [CW-1:0]  min_dist,
   output rti_pkg::ctl_type      out_ctl,
   output logic [TW-1:0]         out_tag,
   output logic [DW-1:0]         out_dsr,
   // lanes: u, v, t - min
   output logic [DVW-1:0]        out_dvd [3]
);

   localparam int RW  = DW + CW + FB + 1;
   localparam int EXW = RW + QB;
   localparam logic [127:0] EPS_K = 128'd1 << (3 * FB);
   localparam logic [127:0] EPS_Q =
      (EPS_K + 128'(rti_pkg::EPS_RECIP) - 128'd1) / 128'(rti_pkg::EPS_RECIP);
   localparam logic signed [DW-1:0] EPS_MIN = DW'(EPS_Q);

   rti_pkg::ctl_type      ctl_ff [3];
   logic [TW-1:0]         tag_ff [3];
   logic signed [DW-1:0]  val_ff [2][4];
   logic signed [CW+DW-1:0] md;
   logic signed [DW:0]    uv_sum;
   logic                  bary_ok;
   logic signed [RW-1:0]  rem_t;
   logic                  dist_ok;
   rti_pkg::ctl_type      ctl_a_in, ctl_c_in;
   logic [DW-1:0]         dsr_ff;
   logic [DVW-1:0]        dvd_ff [3];

   // min_dist * det, lined up with the second stage
   rti_mul #(.WA(CW), .WB(DW), .NCH(3)) u_md (
      .clock(clock), .en(en), .a(min_dist), .b(in_val[0]), .p(md));

   always_comb begin
      uv_sum  = (DW+1)'(in_val[1]) + (DW+1)'(in_val[2]);
      bary_ok = (in_val[0] >= EPS_MIN) && !in_val[1][DW-1] && (in_val[1] <= in_val[0])
                && !in_val[2][DW-1] && (uv_sum <= (DW+1)'(in_val[0]));
      ctl_a_in.valid = in_ctl.valid;
      ctl_a_in.pass  = in_ctl.pass && bary_ok;

      // floor(nt*2^fb/det) >= min  <=>  nt*2^fb - min*det >= 0
      rem_t   = (RW'(val_ff[1][3]) <<< FB) - RW'(md);
      dist_ok = !rem_t[RW-1] && (EXW'(rem_t) < (EXW'(val_ff[1][0]) <<< QB));
      ctl_c_in.valid = ctl_ff[1].valid;
      ctl_c_in.pass  = ctl_ff[1].pass && dist_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) ctl_ff[i] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_a_in;
         ctl_ff[1] <= ctl_ff[0];
         ctl_ff[2] <= ctl_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         tag_ff[1] <= tag_ff[0];
         tag_ff[2] <= tag_ff[1];
         val_ff[0] <= in_val;
         val_ff[1] <= val_ff[0];
         dsr_ff    <= DW'(val_ff[1][0]);
         dvd_ff[0] <= DVW'(val_ff[1][1]) << rti_pkg::BARY_BITS;
         dvd_ff[1] <= DVW'(val_ff[1][2]) << rti_pkg::BARY_BITS;
         dvd_ff[2] <= DVW'(rem_t);
      end
   end

   assign out_ctl = ctl_ff[2];
   assign out_tag = tag_ff[2];
   assign out_dsr = dsr_ff;
   assign out_dvd = dvd_ff;

endmodule

### rtl/core/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// pipelined restoring divider, three lanes sharing one divisor, a bit a stage
// ----------------------------------------------------------------------------
module rti_div #(
   parameter int TW = 24,
   parameter int DW = 102,
   parameter int QB = 32,
   localparam int DVW = DW + QB
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  rti_pkg::ctl_type   in_ctl,
   input  logic [TW-1:0]      in_tag,
   input  logic [DW-1:0]      in_dsr,
   input  logic [DVW-1:0]     in_dvd [3],
   output rti_pkg::ctl_type   out_ctl,
   output logic [TW-1:0]      out_tag,
   output logic [QB-1:0]      out_quo [3]
);

   rti_pkg::ctl_type  ctl_ff [QB];
   logic [TW-1:0]     tag_ff [QB];
   logic [DW-1:0]     dsr_ff [QB];
   logic [DVW-1:0]    rem_ff [QB][3];
   logic [QB-1:0]     quo_ff [QB][3];

   genvar k;
   generate
      for (k = 0; k < QB; k++) begin : g_stage
         rti_pkg::ctl_type  ctl_src;
         logic [TW-1:0]     tag_src;
         logic [DW-1:0]     dsr_src;
         logic [DVW-1:0]    rem_src [3];
         logic [QB-1:0]     quo_src [3];
         logic [DVW-1:0]    trial;
         logic [DVW-1:0]    rem_in [3];
         logic [QB-1:0]     quo_in [3];

         if (k == 0) begin : g_first
            assign ctl_src = in_ctl;
            assign tag_src = in_tag;
            assign dsr_src = in_dsr;
            assign rem_src = in_dvd;
            assign quo_src = '{default: '0};
         end else begin : g_next
            assign ctl_src = ctl_ff[k-1];
            assign tag_src = tag_ff[k-1];
            assign dsr_src = dsr_ff[k-1];
            assign rem_src = rem_ff[k-1];
            assign quo_src = quo_ff[k-1];
         end

         always_comb begin
            trial = DVW'(dsr_src) << (QB - 1 - k);
            for (int l = 0; l < 3; l++) begin
               quo_in[l] = quo_src[l];
               if (rem_src[l] >= trial) begin
                  rem_in[l] = rem_src[l] - trial;
                  quo_in[l][QB-1-k] = 1'b1;
               end else begin
                  rem_in[l] = rem_src[l];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else if (en) begin
               ctl_ff[k] <= ctl_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               tag_ff[k] <= tag_src;
               dsr_ff[k] <= dsr_src;
               rem_ff[k] <= rem_in;
               quo_ff[k] <= quo_in;
            end
         end
      end
   endgenerate

   assign out_ctl = ctl_ff[QB-1];
   assign out_tag = tag_ff[QB-1];
   assign out_quo = quo_ff[QB-1];

endmodule

### bench/ray_triangle_intersect_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb
// self-checking bench for the moller-trumbore ray/triangle pipeline
// ----------------------------------------------------------------------------
// Programs a series of rays through the csr port and streams triangles past
// each one: a directed set of edge and vertex hits, parallel and degenerate
// triangles and extreme coordinates, then random triangles placed around the
// ray with some pure noise. Every accepted triangle is run through an exact
// wide-integer intersection model and the result beats are checked in order.
// Both sides idle at random and the result side holds off for a long stretch.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W = 312;
   localparam int RSP_W = 120;

   typedef logic signed [255:0] wint;

   typedef struct {
      logic [23:0]                tag;
      logic                       hit;
      logic [rti_pkg::BARY_W-1:0] u;
      logic [rti_pkg::BARY_W-1:0] v;
      logic [31:0]                distance;
   } isect_type;

   class isect_scoreboard;
      logic [31:0] ray_reg [8];
      isect_type   pending_hits [$];
      int          errors;

      function new();
         foreach (ray_reg[i]) ray_reg[i] = '0;
         ray_reg[rti_pkg::REG_MAX_DIST] = 32'h7fff_ffff;
         errors = 0;
      endfunction

      function int size();
         return pending_hits.size();
      endfunction

      // exact intersection of one triangle beat with the current ray
      function void note_triangle(logic [REQ_W-1:0] beat);
         wint a [3], e1 [3], e2 [3], s [3], dir [3], p [3], q [3];
         wint det, nu, nv, nt, num, tq;
         isect_type r;
         r.tag = beat[23:0];
         r.hit = 1'b0;
         r.u = '0;
         r.v = '0;
         r.distance = '0;
         for (int i = 0; i < 3; i++) begin
            a[i]   = wint'($signed(beat[24 + 32*i +: 32]));
            e1[i]  = wint'($signed(beat[120 + 32*i +: 32])) - a[i];
            e2[i]  = wint'($signed(beat[216 + 32*i +: 32])) - a[i];
            s[i]   = wint'($signed(ray_reg[i])) - a[i];
            dir[i] = wint'($signed(ray_reg[3 + i]));
         end
         p[0] = dir[1]*e2[2] - dir[2]*e2[1];
         p[1] = dir[2]*e2[0] - dir[0]*e2[2];
         p[2] = dir[0]*e2[1] - dir[1]*e2[0];
         q[0] = s[1]*e1[2] - s[2]*e1[1];
         q[1] = s[2]*e1[0] - s[0]*e1[2];
         q[2] = s[0]*e1[1] - s[1]*e1[0];
         det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
         nu  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
         nv  = dir[0]*q[0] + dir[1]*q[1] + dir[2]*q[2];
         nt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
         if (det < 0) begin
            det = -det;
            nu = -nu;
            nv = -nv;
            nt = -nt;
         end
         // |det| below 1e-8 in real units counts as parallel
         if (det * wint'(rti_pkg::EPS_RECIP) >= (wint'(1) <<< 48) && nu >= 0 &&
             nu <= det && nv >= 0 && nu + nv <= det) begin
            num = nt <<< 16;
            if (num < 0) tq = -((-num + det - 1) / det);
            else tq = num / det;
            if (tq >= wint'($signed(ray_reg[rti_pkg::REG_MIN_DIST])) &&
                tq <= wint'($signed(ray_reg[rti_pkg::REG_MAX_DIST]))) begin
               r.hit = 1'b1;
               r.u = rti_pkg::BARY_W'((nu <<< rti_pkg::BARY_BITS) / det);
               r.v = rti_pkg::BARY_W'((nv <<< rti_pkg::BARY_BITS) / det);
               r.distance = tq[31:0];
            end
         end
         pending_hits.push_back(r);
      endfunction

      function void check_result(logic [RSP_W-1:0] beat, logic hit);
         isect_type e;
         if (pending_hits.size() == 0) begin
            $display("%0t: result beat with nothing expected, tag %h", $realtime, beat[23:0]);
            errors++;
            return;
         end
         e = pending_hits.pop_front();
         if (beat[23:0] !== e.tag) begin
            $display("%0t: tag expected %h actual %h", $realtime, e.tag, beat[23:0]);
            errors++;
         end
         if (hit !== e.hit) begin
            $display("%0t: hit expected %b actual %b (tag %h)", $realtime, e.hit, hit, e.tag);
            errors++;
         end
         if (beat[54:24] !== e.u) begin
            $display("%0t: bary_u expected %h actual %h (tag %h)", $realtime, e.u, beat[54:24],
                     e.tag);
            errors++;
         end
         if (beat[85:55] !== e.v) begin
            $display("%0t: bary_v expected %h actual %h (tag %h)", $realtime, e.v, beat[85:55],
                     e.tag);
            errors++;
         end
         if (beat[117:86] !== e.distance) begin
            $display("%0t: hit_distance expected %h actual %h (tag %h)", $realtime,
                     e.distance, beat[117:86], e.tag);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [REQ_W-1:0]              req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [RSP_W-1:0]              rsp_tdata;
   logic                          rsp_tuser;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [rti_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                   csr_wdata;

   isect_scoreboard sb = new();
   bit no_idle = 0;
   int hold_len = 0;
   logic [23:0] next_tag = 0;

   ray_triangle_intersect u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 5);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_triangle(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         n = idle_cycles();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic write_reg(logic [rti_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.ray_reg[idx] = val;
   endtask

   task automatic set_ray(logic [31:0] r [8]);
      write_reg(rti_pkg::REG_ORIGIN_X, r[0]);
      write_reg(rti_pkg::REG_ORIGIN_Y, r[1]);
      write_reg(rti_pkg::REG_ORIGIN_Z, r[2]);
      write_reg(rti_pkg::REG_DIR_X, r[3]);
      write_reg(rti_pkg::REG_DIR_Y, r[4]);
      write_reg(rti_pkg::REG_DIR_Z, r[5]);
      write_reg(rti_pkg::REG_MIN_DIST, r[6]);
      write_reg(rti_pkg::REG_MAX_DIST, r[7]);
      csr_valid <= 1'b0;
   endtask

   task automatic send_triangle(logic [23:0] tag, logic [31:0] vtx [9]);
      int n;
      n = idle_cycles();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tdata <= {vtx[8], vtx[7], vtx[6], vtx[5], vtx[4], vtx[3], vtx[2], vtx[1], vtx[0], tag};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // wait out the pipe before touching the ray registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_plain(int ax, int ay, int az, int bx, int by, int bz,
                             int cx, int cy, int cz);
      logic [31:0] vtx [9];
      vtx = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      send_triangle(next_tag, vtx);
      next_tag++;
   endtask

   // triangle spread around the point the ray reaches at a random distance, or pure noise
   task automatic send_near_ray();
      logic [31:0] vtx [9];
      longint hitp [3];
      longint t0, spread;
      int r;
      r = $urandom_range(99);
      if (r < 20) begin
         foreach (vtx[i]) vtx[i] = $urandom();
      end else begin
         t0 = $urandom_range(64 << 16);
         if ($urandom_range(9) == 0) t0 = -t0;
         spread = longint'(1) << $urandom_range(22, 8);
         for (int i = 0; i < 3; i++)
            hitp[i] = longint'($signed(sb.ray_reg[i])) +
                      ((longint'($signed(sb.ray_reg[3 + i])) * t0) >>> 16);
         foreach (vtx[i])
            vtx[i] = 32'(hitp[i % 3] + longint'($urandom_range(32'(2*spread))) - spread);
      end
      send_triangle(24'($urandom()), vtx);
   endtask

   initial begin
      logic [31:0] ray [8];
      logic [31:0] vtx [9];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = rti_pkg::REG_ORIGIN_X;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset ray has zero direction: everything is parallel
      foreach (vtx[i]) vtx[i] = 32'h8000_0000;
      send_triangle(24'hff_ffff, vtx);
      foreach (vtx[i]) vtx[i] = 32'h7fff_ffff;
      send_triangle(24'h00_0000, vtx);
      vtx = '{32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0,
              0, 32'h7fff_ffff, 32'h8000_0000};
      send_triangle(24'ha5_5a5a, vtx);
      drain();

      // ray from z=-10 along +z through the origin
      ray = '{0, 0, -(10 << 16), 0, 0, 1 << 16, 0, 32'h7fff_ffff};
      set_ray(ray);
      send_plain(-65536, -65536, 0, 131072, 0, 0, 0, 131072, 0);     // plain hit
      send_plain(0, 0, 0, 65536, 0, 0, 0, 65536, 0);                 // through vertex a
      send_plain(-65536, 0, 0, 0, 0, 0, 0, 65536, 0);                // through vertex b
      send_plain(-65536, 0, 0, 0, 65536, 0, 0, 0, 0);                // through vertex c
      send_plain(-65536, -65536, 0, 65536, 65536, 0, -65536, 65536, 0); // on edge a-b
      send_plain(-65536, -65536, 0, 0, 131072, 0, 131072, 0, 0);     // opposite winding
      send_plain(65536, 65536, 0, 131072, 65536, 0, 65536, 131072, 0); // beside
      send_plain(-65536, -65536, -(20 << 16), 131072, 0, -(20 << 16),
                 0, 131072, -(20 << 16));                             // behind origin
      send_plain(-65536, 0, 0, 0, 0, 65536, 65536, 0, 131072);       // edge-on to ray
      send_plain(0, 0, 0, 0, 0, 0, 0, 0, 0);                         // degenerate
      send_plain(-1, -1, 0, 1, 0, 0, 0, 1, 0);                       // tiny, near parallel
      send_plain(-300, -300, 0, 600, 0, 0, 0, 600, 0);               // small but valid
      send_plain(-65536, -65536, 3, 131072, 0, 5, 0, 131072, 7);     // non integer t
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         foreach (ray[i]) ray[i] = 32'($signed($urandom_range(1 << 22)) - (1 << 21));
         for (int i = 3; i < 6; i++)
            ray[i] = 32'($signed($urandom_range(1 << 18)) - (1 << 17));
         ray[6] = 0;
         ray[7] = 32'h7fff_ffff;
         case (ph)
            2: ray = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff};
            3: ray[6] = 32'($signed(-$urandom_range(20 << 16)));
            4: begin                                       // empty interval
               ray[6] = 32'h7fff_ffff;
               ray[7] = 32'h8000_0000;
            end
            5: begin
               ray[6] = $urandom_range(8 << 16);
               ray[7] = ray[6] + $urandom_range(24 << 16);
            end
            6: ray[3] = 0;
            default: ;
         endcase
         set_ray(ray);
         no_idle = (ph == 3);
         if (ph == 1) hold_len = 400;
         repeat (90) send_near_ray();
         drain();
      end

      if (sb.errors == 0 && sb.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
